[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands on aclk with the synchronous active-low
// reset aresetn. They compile to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PIP_ASSERT_IMP(lbl, ante, cons, msg)
`define PIP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Widths, codes, types and the saturating offset adder shared by the block.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int FRAC_BITS    = COORD_WIDTH - 4;
    localparam int MAX_VERTICES = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int NUM_W        = $clog2(MAX_VERTICES + 1);
    localparam int COUNT_W      = 5;
    localparam int INDEX_W      = 4;
    localparam int ACTION_W     = 2;
    localparam int SUM_W        = COORD_WIDTH + 1;
    localparam int DIFF_W       = COORD_WIDTH + 2;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int S_TDATA_W    = ((INDEX_W + 2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W    = 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t VIEW_ONE     = COORD_WIDTH'(1 << FRAC_BITS);
    localparam coord_t VIEW_NEG_ONE = COORD_WIDTH'(-(1 << FRAC_BITS));
    localparam coord_t COORD_MAX    = COORD_WIDTH'((1 << (COORD_WIDTH - 1)) - 1);
    localparam coord_t COORD_MIN    = COORD_WIDTH'(1 << (COORD_WIDTH - 1));

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE_VERTEX = 2'd0,
        ACT_TRANSLATE    = 2'd1,
        ACT_QUERY        = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Control from the sequencer to the edge unit.
    typedef struct packed {
        logic clear;     // start of a query: reset parity and bounding box
        logic rd_vld;    // vertex read data is valid this cycle
        logic rd_first;  // this read is the closing vertex, not an edge end
    } pip_edge_ctl_t;

    // Status back from the edge unit.
    typedef struct packed {
        logic busy;
        logic in_poly;
        logic out_of_view;
    } pip_edge_sts_t;

    // Adds two coordinates and clamps the sum to the coordinate range.
    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic signed [SUM_W-1:0] sum;
        sum = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            sat_add = sum[SUM_W-1] ? COORD_MIN : COORD_MAX;
        end else begin
            sat_add = sum[COORD_WIDTH-1:0];
        end
    endfunction

endpackage

[hw/rtl/pip_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/pip_edge.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon edge unit
// Takes one vertex a cycle from the vertex memory, forms the edge to the
// previous vertex, and runs the exact crossing test in four stages. It also
// keeps the bounding box of the raw vertices for the off-screen flag.
// ----------------------------------------------------------------------------
module pip_edge import pip_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  pip_edge_ctl_t ctl,
    input  coord_t        rd_x,
    input  coord_t        rd_y,
    input  coord_t        off_x,
    input  coord_t        off_y,
    input  coord_t        pt_x,
    input  coord_t        pt_y,
    output pip_edge_sts_t sts
);

    // Stage 1: offset vertex, previous vertex, bounding box.
    logic signed [SUM_W-1:0]  cur_x_reg, cur_y_reg, prv_x_reg, prv_y_reg;
    logic                     s1_vld_reg;
    coord_t                   xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    // Stage 2: differences.
    logic signed [DIFF_W-1:0] a_reg, c_reg, d_reg, e_reg;
    logic signed [DIFF_W-1:0] a_w, c_w, d_w, e_w;
    logic signed [SUM_W-1:0]  pt_y_ext;
    logic                     s2_vld_reg, s2_straddle_reg, den_pos_reg;
    // Stage 3: products.
    logic signed [DIFF_W-1:0] l_op_a, l_op_b, r_op_a, r_op_b;
    logic signed [PROD_W-1:0] prod_l_reg, prod_r_reg;
    logic                     s3_vld_reg, s3_straddle_reg;
    // Stage 4: parity.
    logic                     inside_reg;

    always_ff @(posedge aclk) begin
        if (ctl.rd_vld) begin
            cur_x_reg <= {rd_x[COORD_WIDTH-1], rd_x} + {off_x[COORD_WIDTH-1], off_x};
            cur_y_reg <= {rd_y[COORD_WIDTH-1], rd_y} + {off_y[COORD_WIDTH-1], off_y};
            prv_x_reg <= cur_x_reg;
            prv_y_reg <= cur_y_reg;
        end
        if (ctl.clear) begin
            xmin_reg <= VIEW_ONE;
            ymin_reg <= VIEW_ONE;
            xmax_reg <= VIEW_NEG_ONE;
            ymax_reg <= VIEW_NEG_ONE;
        end else if (ctl.rd_vld && !ctl.rd_first) begin
            if (rd_x < xmin_reg) xmin_reg <= rd_x;
            if (rd_x > xmax_reg) xmax_reg <= rd_x;
            if (rd_y < ymin_reg) ymin_reg <= rd_y;
            if (rd_y > ymax_reg) ymax_reg <= rd_y;
        end
    end

    assign pt_y_ext = {pt_y[COORD_WIDTH-1], pt_y};
    assign a_w = {{2{pt_x[COORD_WIDTH-1]}}, pt_x} - {cur_x_reg[SUM_W-1], cur_x_reg};
    assign e_w = {{2{pt_y[COORD_WIDTH-1]}}, pt_y} - {cur_y_reg[SUM_W-1], cur_y_reg};
    assign c_w = {prv_x_reg[SUM_W-1], prv_x_reg} - {cur_x_reg[SUM_W-1], cur_x_reg};
    assign d_w = {prv_y_reg[SUM_W-1], prv_y_reg} - {cur_y_reg[SUM_W-1], cur_y_reg};

    always_ff @(posedge aclk) begin
        a_reg           <= a_w;
        c_reg           <= c_w;
        d_reg           <= d_w;
        e_reg           <= e_w;
        s2_straddle_reg <= (cur_y_reg > pt_y_ext) != (prv_y_reg > pt_y_ext);
        den_pos_reg     <= !d_w[DIFF_W-1] && (|d_w);
    end

    // With a positive denominator the test is (x-cx)*den < (px-cx)*(y-cy);
    // with a negative one both sides swap places.
    assign l_op_a = den_pos_reg ? a_reg : c_reg;
    assign l_op_b = den_pos_reg ? d_reg : e_reg;
    assign r_op_a = den_pos_reg ? c_reg : a_reg;
    assign r_op_b = den_pos_reg ? e_reg : d_reg;

    always_ff @(posedge aclk) begin
        prod_l_reg      <= l_op_a * l_op_b;
        prod_r_reg      <= r_op_a * r_op_b;
        s3_straddle_reg <= s2_straddle_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            inside_reg <= 1'b0;
        end else begin
            s1_vld_reg <= ctl.rd_vld && !ctl.rd_first;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (ctl.clear) begin
                inside_reg <= 1'b0;
            end else if (s3_vld_reg && s3_straddle_reg && (prod_l_reg < prod_r_reg)) begin
                inside_reg <= !inside_reg;
            end
        end
    end

    assign sts.busy        = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign sts.in_poly     = inside_reg;
    assign sts.out_of_view = (xmax_reg <= VIEW_NEG_ONE) || (xmin_reg >= VIEW_ONE) ||
                             (ymax_reg <= VIEW_NEG_ONE) || (ymin_reg >= VIEW_ONE);

endmodule

[hw/rtl/point_in_polygon_test_unit.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon test unit
// Even-odd ray-casting test of a point against a stored, offset polygon, plus
// an off-screen bounding-box flag on the un-offset vertices.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake           Word contents
//  s_       in   s_tvalid/s_tready   tuser: action; tdata: index, x, y
//  m_       out  m_tvalid/m_tready   tdata: inside_res, out_of_view
//  cfg_     in   cfg_valid/cfg_ready cfg_data: vertex_count
//
// Write-vertex and translate words never leave the idle state. A query over n
// vertices (vertex_count clamped to the capacity) makes n + 1 vertex reads,
// the closing vertex first, then drains the edge unit and loads the result.
// A query with no vertices skips the walk and answers with both flags clear.
// Reset is synchronous and active low and leaves the vertex memory uncleared.
// Words are taken while a result waits; a finished query waits until that one is taken.
//
`include "assert_macros.svh"

module point_in_polygon_test_unit import pip_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input words.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [3:0] vertex_index, [19:4] coord_x, [35:20] coord_y, rest zero.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] action.
    input  logic [ACTION_W-1:0]  s_tuser,
    // Result words.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] inside_res, [1] out_of_view, rest zero.
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration: vertex_count.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COUNT_W-1:0]   cfg_data
);

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    vertex_count_reg;
    coord_t                off_x_reg, off_y_reg;
    coord_t                pt_x_reg, pt_y_reg;
    logic [NUM_W-1:0]      n_used_reg, n_used_now;
    logic [NUM_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  rd_vld_reg, rd_first_reg;
    logic                  empty_reg;
    logic                  m_valid_reg, inside_res_reg, out_of_view_reg;

    action_t               in_action;
    logic [INDEX_W-1:0]    in_index;
    coord_t                in_x, in_y;
    logic                  s_acc;
    logic                  query_start, load_out;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [2*COORD_WIDTH-1:0] ram_rdata;
    coord_t                rd_x, rd_y;

    pip_edge_ctl_t         edge_ctl;
    pip_edge_sts_t         edge_sts;

    // Unpack the input word.
    assign in_action = action_t'(s_tuser);
    assign in_index  = s_tdata[INDEX_W-1:0];
    assign in_x      = s_tdata[INDEX_W +: COORD_WIDTH];
    assign in_y      = s_tdata[INDEX_W + COORD_WIDTH +: COORD_WIDTH];
    assign s_acc     = s_tvalid && s_tready;

    // A count above the capacity acts as the capacity.
    assign n_used_now = (32'(vertex_count_reg) > MAX_VERTICES) ?
                        NUM_W'(MAX_VERTICES) : NUM_W'(vertex_count_reg);

    assign cfg_ready = 1'b1;

    // Vertex memory: x in the upper half of the word, y in the lower.
    assign ram_we = s_acc && (in_action == ACT_WRITE_VERTEX) &&
                    (32'(in_index) < MAX_VERTICES);

    // The walk reads the closing vertex first so that it is already held as
    // the previous vertex when vertex zero arrives.
    assign ram_raddr = (rd_idx_reg == '0) ? ADDR_W'(n_used_reg - NUM_W'(1))
                                          : ADDR_W'(rd_idx_reg - NUM_W'(1));

    pip_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ADDR_W'(in_index)),
        .wr_data ({in_x, in_y}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_x = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign rd_y = ram_rdata[COORD_WIDTH-1:0];

    assign edge_ctl.clear    = query_start;
    assign edge_ctl.rd_vld   = rd_vld_reg;
    assign edge_ctl.rd_first = rd_first_reg;

    pip_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (edge_ctl),
        .rd_x    (rd_x),
        .rd_y    (rd_y),
        .off_x   (off_x_reg),
        .off_y   (off_y_reg),
        .pt_x    (pt_x_reg),
        .pt_y    (pt_y_reg),
        .sts     (edge_sts)
    );

    // Sequencer: one word at a time; writes and translates finish in the
    // accepting cycle, a query walks the polygon and drains the edge unit.
    // In the idle state the input is always ready, so tvalid alone marks an
    // accepted word there.
    always_comb begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        s_tready    = 1'b0;
        query_start = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && (in_action == ACT_QUERY)) begin
                    query_start = 1'b1;
                    rd_idx_next = '0;
                    state_next  = (n_used_now == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                rd_idx_next = rd_idx_reg + NUM_W'(1);
                if (rd_idx_reg == n_used_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !edge_sts.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= '0;
            off_x_reg        <= '0;
            off_y_reg        <= '0;
            rd_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            rd_first_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            rd_vld_reg   <= (state_reg == ST_WALK);
            rd_first_reg <= (state_reg == ST_WALK) && (rd_idx_reg == '0);
            if (cfg_valid && cfg_ready) begin
                vertex_count_reg <= cfg_data;
            end
            if (s_acc && (in_action == ACT_TRANSLATE)) begin
                off_x_reg <= sat_add(off_x_reg, in_x);
                off_y_reg <= sat_add(off_y_reg, in_y);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Query operands and the result payload need no reset.
    always_ff @(posedge aclk) begin
        if (query_start) begin
            pt_x_reg   <= in_x;
            pt_y_reg   <= in_y;
            n_used_reg <= n_used_now;
            empty_reg  <= (n_used_now == '0);
        end
        if (load_out) begin
            inside_res_reg  <= !empty_reg && edge_sts.in_poly;
            out_of_view_reg <= !empty_reg && edge_sts.out_of_view;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, out_of_view_reg, inside_res_reg};

    // New words are taken only once no vertex read or edge is in flight.
    `PIP_ASSERT_IMP(a_ready_when_quiet, s_tready, !rd_vld_reg && !edge_sts.busy, "input taken while an edge is in flight")
    // A result appears only as the close of a query.
    `PIP_ASSERT_IMP(a_result_from_query, $rose(m_valid_reg), $past(state_reg == ST_DONE), "result word without a finished query")
    // The walk never reads beyond the vertices in use.
    `PIP_ASSERT_IMP(a_walk_in_range, state_reg == ST_WALK, (rd_idx_reg <= n_used_reg) && (n_used_reg != '0), "polygon walk out of range")
    // A query started with vertices in use always walks.
    `PIP_ASSERT_NXT(a_query_walks, query_start && (n_used_now != '0), state_reg == ST_WALK && rd_idx_reg == '0, "query did not start the walk")

endmodule
